>>> design/pidc_pkg.sv
package pidc_pkg;

    // Q16.16 limits and the reset values of the bound registers.
    localparam logic signed [31:0] Q_MAX          = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN          = 32'sh8000_0000;
    localparam logic signed [31:0] BOUND_LOW_RST  = 32'shFFFF_0000;
    localparam logic signed [31:0] BOUND_HIGH_RST = 32'sh0001_0000;

    // Quotient bits produced by the divider: a 33-bit error change scaled by 2^16.
    localparam int DIV_STEPS = 49;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_GAIN_P,
        CFG_GAIN_I,
        CFG_GAIN_D,
        CFG_DRIVE_LOW,
        CFG_DRIVE_HIGH,
        CFG_ACCUM_LOW,
        CFG_ACCUM_HIGH
    } cfg_idx_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REJ,
        ST_ERR,
        ST_MUL_P,
        ST_WB_P,
        ST_MUL_E,
        ST_WB_E,
        ST_ACC,
        ST_MUL_I,
        ST_WB_I,
        ST_DIV_WAIT,
        ST_MUL_D,
        ST_WB_D,
        ST_SUM,
        ST_FIN
    } state_t;

    // Operand pair for the shared multiplier.
    typedef enum logic [1:0] {
        MS_P,
        MS_E,
        MS_I,
        MS_D
    } mul_sel_t;

    // Destination of a scaled product.
    typedef enum logic [2:0] {
        WB_NONE,
        WB_P,
        WB_E,
        WB_I,
        WB_D
    } wb_sel_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic     ld_in;
        logic     ld_err;
        logic     div_start;
        logic     mul_en;
        mul_sel_t mul_sel;
        wb_sel_t  wb_sel;
        logic     acc_upd;
        logic     sum_ld;
        logic     out_ld;
        logic     out_rej;
    } dp_cmd_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic dt_bad;
        logic have_last;
        logic div_busy;
        logic div_done;
    } dp_stat_t;

    // Take a Q32.32 product back to Q16.16: floor shift by 16, then saturate.
    function automatic logic signed [31:0] qsat(input logic signed [63:0] prod);
        logic [47:0] sh;
        sh = prod[63:16];
        if (sh[47:31] != {17{sh[47]}}) begin
            return sh[47] ? Q_MIN : Q_MAX;
        end
        return sh[31:0];
    endfunction

    // Clamp a wide sum to a pair of bounds that may be given in either order.
    function automatic logic signed [31:0] clamp_ord(input logic signed [33:0] x,
                                                     input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [33:0] lo_x;
        logic signed [33:0] hi_x;
        lo   = (a < b) ? a : b;
        hi   = (a < b) ? b : a;
        lo_x = {{2{lo[31]}}, lo};
        hi_x = {{2{hi[31]}}, hi};
        if (x < lo_x) begin
            return lo;
        end
        if (x > hi_x) begin
            return hi;
        end
        return x[31:0];
    endfunction

endpackage

>>> design/pidc_div.sv
module pidc_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [48:0]         dividend,
    input  logic                neg,
    input  logic [30:0]         divisor,
    output logic                busy,
    output logic                done,
    output logic signed [31:0]  quot
);
    import pidc_pkg::*;

    localparam logic [5:0] LAST_STEP = 6'(DIV_STEPS - 1);

    logic               busy_reg;
    logic               done_reg;
    logic [5:0]         cnt_reg;
    logic [30:0]        rem_reg;
    logic [48:0]        num_reg;
    logic [30:0]        dvs_reg;
    logic               neg_reg;
    logic signed [31:0] quot_reg;

    logic [32:0]        trial;
    logic               ge;
    logic [30:0]        rem_next;
    logic [48:0]        num_next;
    logic signed [31:0] quot_next;

    // One restoring step: bring down the next dividend bit and try the subtraction.
    always_comb begin
        trial    = {1'b0, rem_reg, num_reg[48]} - {2'b00, dvs_reg};
        ge       = !trial[32];
        rem_next = ge ? trial[30:0] : {rem_reg[29:0], num_reg[48]};
        num_next = {num_reg[47:0], ge};
    end

    // Signed saturation of the finished magnitude quotient.
    always_comb begin
        if (neg_reg) begin
            if ((|num_next[48:32]) || (num_next[31] && (|num_next[30:0]))) begin
                quot_next = Q_MIN;
            end else begin
                quot_next = -num_next[31:0];
            end
        end else begin
            quot_next = (|num_next[48:31]) ? Q_MAX : num_next[31:0];
        end
    end

    // Control: busy while iterating, done held until the next start.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == LAST_STEP) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Working registers of the division.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            num_reg <= dividend;
            dvs_reg <= divisor;
            neg_reg <= neg;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            num_reg <= num_next;
            if (cnt_reg == LAST_STEP) begin
                quot_reg <= quot_next;
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

>>> design/pidc_datapath.sv
module pidc_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic [95:0]        s_tdata,
    input  pidc_pkg::dp_cmd_t  cmd,
    output pidc_pkg::dp_stat_t stat,
    output logic [31:0]        m_tdata,
    output logic               m_tuser
);
    import pidc_pkg::*;

    logic signed [31:0] gain_p_reg;
    logic signed [31:0] gain_i_reg;
    logic signed [31:0] gain_d_reg;
    logic signed [31:0] drive_low_reg;
    logic signed [31:0] drive_high_reg;
    logic signed [31:0] accum_low_reg;
    logic signed [31:0] accum_high_reg;

    logic signed [31:0] tgt_reg;
    logic signed [31:0] meas_reg;
    logic signed [31:0] dt_reg;
    logic signed [31:0] err_reg;
    logic signed [31:0] p_reg;
    logic signed [31:0] inc_reg;
    logic signed [31:0] i_reg;
    logic signed [31:0] d_reg;
    logic signed [33:0] sum_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] drive_reg;
    logic               rej_reg;

    logic signed [31:0] acc_reg;
    logic signed [31:0] last_err_reg;
    logic               have_last_reg;

    logic [32:0]        diff_in;
    logic signed [31:0] err_next;
    logic [32:0]        delta;
    logic [32:0]        delta_mag;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [31:0] prod_q;
    logic signed [33:0] acc_sum;
    logic               div_busy;
    logic               div_done;
    logic signed [31:0] div_q;

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            drive_low_reg  <= BOUND_LOW_RST;
            drive_high_reg <= BOUND_HIGH_RST;
            accum_low_reg  <= BOUND_LOW_RST;
            accum_high_reg <= BOUND_HIGH_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_GAIN_P:     gain_p_reg     <= cfg_wdata;
                CFG_GAIN_I:     gain_i_reg     <= cfg_wdata;
                CFG_GAIN_D:     gain_d_reg     <= cfg_wdata;
                CFG_DRIVE_LOW:  drive_low_reg  <= cfg_wdata;
                CFG_DRIVE_HIGH: drive_high_reg <= cfg_wdata;
                CFG_ACCUM_LOW:  accum_low_reg  <= cfg_wdata;
                CFG_ACCUM_HIGH: accum_high_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Saturated error, and the error change that feeds the divider.
    always_comb begin
        diff_in   = {tgt_reg[31], tgt_reg} - {meas_reg[31], meas_reg};
        err_next  = (diff_in[32] != diff_in[31]) ? (diff_in[32] ? Q_MIN : Q_MAX)
                                                 : diff_in[31:0];
        delta     = {err_reg[31], err_reg} - {last_err_reg[31], last_err_reg};
        delta_mag = delta[32] ? -delta : delta;
    end

    // Shared multiplier operand selection.
    always_comb begin
        unique case (cmd.mul_sel)
            MS_P: begin
                mul_a = gain_p_reg;
                mul_b = err_reg;
            end
            MS_E: begin
                mul_a = err_reg;
                mul_b = dt_reg;
            end
            MS_I: begin
                mul_a = gain_i_reg;
                mul_b = acc_reg;
            end
            MS_D: begin
                mul_a = gain_d_reg;
                mul_b = div_q;
            end
            default: begin
                mul_a = gain_p_reg;
                mul_b = err_reg;
            end
        endcase
    end

    assign prod_q  = qsat(prod_reg);
    assign acc_sum = {{2{acc_reg[31]}}, acc_reg} + {{2{inc_reg[31]}}, inc_reg};

    // Error change scaled by 2^16 over the time step.
    pidc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend ({delta_mag, 16'h0000}),
        .neg      (delta[32]),
        .divisor  (dt_reg[30:0]),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_q)
    );

    // Working registers of one update.
    always_ff @(posedge aclk) begin
        if (cmd.ld_in) begin
            tgt_reg  <= s_tdata[31:0];
            meas_reg <= s_tdata[63:32];
            dt_reg   <= s_tdata[95:64];
        end
        if (cmd.ld_err) begin
            err_reg <= err_next;
            d_reg   <= '0;
        end
        if (cmd.mul_en) begin
            prod_reg <= 64'(mul_a) * 64'(mul_b);
        end
        unique case (cmd.wb_sel)
            WB_P:    p_reg   <= prod_q;
            WB_E:    inc_reg <= prod_q;
            WB_I:    i_reg   <= prod_q;
            WB_D:    d_reg   <= prod_q;
            default: ;
        endcase
        if (cmd.sum_ld) begin
            sum_reg <= {{2{p_reg[31]}}, p_reg} + {{2{i_reg[31]}}, i_reg}
                     + {{2{d_reg[31]}}, d_reg};
        end
        if (cmd.out_ld) begin
            drive_reg <= cmd.out_rej ? '0
                                     : clamp_ord(sum_reg, drive_low_reg, drive_high_reg);
            rej_reg   <= cmd.out_rej;
        end
    end

    // Controller state kept between updates; a rejected step leaves it alone.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            last_err_reg  <= '0;
            have_last_reg <= 1'b0;
        end else begin
            if (cmd.acc_upd) begin
                acc_reg <= clamp_ord(acc_sum, accum_low_reg, accum_high_reg);
            end
            if (cmd.out_ld && !cmd.out_rej) begin
                last_err_reg  <= err_reg;
                have_last_reg <= 1'b1;
            end
        end
    end

    always_comb begin
        stat.dt_bad    = s_tdata[95] || (s_tdata[95:64] == 32'h0000_0000);
        stat.have_last = have_last_reg;
        stat.div_busy  = div_busy;
        stat.div_done  = div_done;
    end

    assign m_tdata = drive_reg;
    assign m_tuser = rej_reg;

endmodule

>>> design/pidc_ctrl.sv
module pidc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  pidc_pkg::dp_stat_t stat,
    output pidc_pkg::dp_cmd_t  cmd
);
    import pidc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    // State and output-valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    // Next state and datapath commands.
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = MS_P;
        cmd.wb_sel  = WB_NONE;
        s_tready    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.ld_in  = 1'b1;
                    state_next = stat.dt_bad ? ST_REJ : ST_ERR;
                end
            end
            ST_REJ: begin
                if (out_free) begin
                    cmd.out_ld  = 1'b1;
                    cmd.out_rej = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_ERR: begin
                cmd.ld_err = 1'b1;
                state_next = ST_MUL_P;
            end
            ST_MUL_P: begin
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MS_P;
                cmd.div_start = stat.have_last;
                state_next    = ST_WB_P;
            end
            ST_WB_P: begin
                cmd.wb_sel = WB_P;
                state_next = ST_MUL_E;
            end
            ST_MUL_E: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_E;
                state_next  = ST_WB_E;
            end
            ST_WB_E: begin
                cmd.wb_sel = WB_E;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc_upd = 1'b1;
                state_next  = ST_MUL_I;
            end
            ST_MUL_I: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_I;
                state_next  = ST_WB_I;
            end
            ST_WB_I: begin
                cmd.wb_sel = WB_I;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                // No derivative on the first accepted step after reset.
                if (!stat.have_last) begin
                    state_next = ST_SUM;
                end else if (stat.div_done) begin
                    state_next = ST_MUL_D;
                end
            end
            ST_MUL_D: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_D;
                state_next  = ST_WB_D;
            end
            ST_WB_D: begin
                cmd.wb_sel = WB_D;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum_ld = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd.out_ld = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The output register fills on a load and empties on a transfer.
    always_comb begin
        if (cmd.out_ld) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

>>> design/pid_controller_clamped.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  s_tdata: target, measured, step_time
// m_        out        m_tvalid/m_tready  m_tdata: drive; m_tuser: step_rejected
// cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// A rejected step skips the arithmetic; until a step has been accepted after reset there
// is no derivative, and every later step also waits on the bit-serial divider for it.
// One shared 32x32 multiplier forms the four products in turn.
// Reset is synchronous and active low; it clears the controller state, the
// configuration registers and the output valid.
// A result held in the output register does not block the next input transfer;
// the update stalls only at its end until that register is free.
module pid_controller_clamped (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // target [31:0], measured [63:32], step_time [95:64]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // drive [31:0]
    output logic        m_tuser    // step_rejected [0]
);
    import pidc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    pidc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pidc_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // A rejected step always carries a zero drive.
    a_rej_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == 32'h0000_0000))
        else $error("rejected step with non-zero drive");

    // The divider is idle whenever a new item can be taken.
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !stat.div_busy)
        else $error("divider still busy at input transfer");

    // Reset empties the output register.
    a_rst_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule
